/* hdl/lfqg_pkg.sv */
package lfqg_pkg;

  localparam int unsigned NUM_SPOTS_DEF = 13;
  localparam int unsigned TABLE_LEN     = 13;
  localparam int unsigned DIV_STEPS     = 8;   // quotient never exceeds 8 bits

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_BORDER   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       fin;
    logic       emit;
    logic       last;
    logic [3:0] spot_index;
    logic [3:0] tab_idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        tex;
    logic signed [9:0] line_pos;  // Q2.8
    logic [11:0]       size;      // Q0.12
    logic [7:0]        r;
    logic [7:0]        g;
    logic [7:0]        b;
    logic [7:0]        a;
  } spot_t;

  function automatic spot_t spot_entry(input logic [3:0] idx);
    spot_t s;
    unique case (idx)
      4'd0:    s = '{2'd0,  10'sd256, 12'd1638, 8'd255, 8'd255, 8'd255, 8'd255};
      4'd1:    s = '{2'd2,  10'sd205, 12'd2048, 8'd179, 8'd128, 8'd0,   8'd51};
      4'd2:    s = '{2'd2,  10'sd179, 12'd20,   8'd255, 8'd0,   8'd0,   8'd179};
      4'd3:    s = '{2'd1,  10'sd154, 12'd102,  8'd255, 8'd255, 8'd0,   8'd128};
      4'd4:    s = '{2'd3,  10'sd128, 12'd205,  8'd255, 8'd255, 8'd0,   8'd128};
      4'd5:    s = '{2'd1,  10'sd102, 12'd102,  8'd255, 8'd128, 8'd0,   8'd255};
      4'd6:    s = '{2'd2,  10'sd26,  12'd102,  8'd255, 8'd255, 8'd128, 8'd128};
      4'd7:    s = '{2'd1, -10'sd51,  12'd102,  8'd255, 8'd0,   8'd0,   8'd255};
      4'd8:    s = '{2'd2, -10'sd77,  12'd184,  8'd255, 8'd255, 8'd153, 8'd128};
      4'd9:    s = '{2'd1, -10'sd102, 12'd287,  8'd255, 8'd179, 8'd0,   8'd77};
      4'd10:   s = '{2'd3, -10'sd179, 12'd287,  8'd255, 8'd128, 8'd0,   8'd51};
      4'd11:   s = '{2'd2, -10'sd256, 12'd655,  8'd255, 8'd179, 8'd0,   8'd102};
      4'd12:   s = '{2'd3, -10'sd333, 12'd819,  8'd255, 8'd0,   8'd0,   8'd179};
      default: s = '{2'd0,  10'sd256, 12'd1638, 8'd255, 8'd255, 8'd255, 8'd255};
    endcase
    return s;
  endfunction

endpackage

/* hdl/lfqg_ctrl.sv */
module lfqg_ctrl #(
  parameter int unsigned NUM_SPOTS = 13
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          light_behind_i,
  output logic          busy,
  output lfqg_pkg::cmd_t cmd_o
);
  import lfqg_pkg::*;

  localparam int unsigned KW = (NUM_SPOTS > 1) ? $clog2(NUM_SPOTS) : 1;

  state_e        state_q, state_d;
  logic [2:0]    step_q, step_d;
  logic [KW-1:0] spot_q, spot_d;
  logic [3:0]    tab_q, tab_d;
  logic          accept;
  logic          spot_last;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign spot_last = (spot_q == KW'(NUM_SPOTS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept && !light_behind_i) state_d = ST_DIV;
      ST_DIV:  if (step_q == 3'(DIV_STEPS - 1)) state_d = ST_FIN;
      ST_FIN:  state_d = ST_EMIT;
      ST_EMIT: if (spot_last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    step_d = step_q;
    spot_d = spot_q;
    tab_d  = tab_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        spot_d = '0;
        tab_d  = '0;
      end
      ST_DIV:  step_d = step_q + 3'd1;
      ST_FIN:  step_d = '0;
      ST_EMIT: begin
        spot_d = spot_q + KW'(1);
        tab_d  = (tab_q == 4'(TABLE_LEN - 1)) ? 4'd0 : tab_q + 4'd1;
      end
      default: step_d = '0;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.spot_index = 4'(spot_q);
    cmd_o.tab_idx    = tab_q;
    unique case (state_q)
      ST_IDLE: cmd_o.load     = accept && !light_behind_i;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_FIN:  cmd_o.fin      = 1'b1;
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = spot_last;
      end
      default: cmd_o.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      spot_q  <= '0;
      tab_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      spot_q  <= spot_d;
      tab_q   <= tab_d;
    end
  end

endmodule

/* hdl/lfqg_datapath.sv */
module lfqg_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lfqg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lfqg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [13:0]                  light_x_i,
  input  logic signed [13:0]                  light_y_i,
  input  lfqg_pkg::cmd_t                      cmd_i,
  output logic                                result_valid_o,
  output logic [3:0]                          spot_index_o,
  output logic [1:0]                          texture_select_o,
  output logic signed [15:0]                  quad_left_o,
  output logic signed [15:0]                  quad_top_o,
  output logic signed [15:0]                  quad_right_o,
  output logic signed [15:0]                  quad_bottom_o,
  output logic [7:0]                          red_o,
  output logic [7:0]                          green_o,
  output logic [7:0]                          blue_o,
  output logic [7:0]                          alpha_o,
  output logic                                last_o
);
  import lfqg_pkg::*;

  // configuration registers
  logic [12:0] sw_q, sh_q;
  logic [7:0]  imin_q, imax_q;
  logic [11:0] fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q   <= 13'd1024;
      sh_q   <= 13'd768;
      imin_q <= 8'd0;
      imax_q <= 8'd255;
      fb_q   <= 12'd300;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SCREEN_WIDTH:  sw_q   <= cfg_data_i;
        REG_SCREEN_HEIGHT: sh_q   <= cfg_data_i;
        REG_INTENSITY_MIN: imin_q <= cfg_data_i[7:0];
        REG_INTENSITY_MAX: imax_q <= cfg_data_i[7:0];
        REG_FADE_BORDER:   fb_q   <= cfg_data_i[11:0];
        default:           ;
      endcase
    end
  end

  // ---- load: fade distance and divider set-up
  logic [11:0] border;
  logic [13:0] ax, ay, away;
  logic [11:0] capped, n_fade;
  logic        up;
  logic [7:0]  diff;
  logic [19:0] fade_prod;
  logic [11:0] cx, cy;

  assign border = (fb_q == 12'd0) ? 12'd1 : fb_q;
  assign ax     = light_x_i[13] ? 14'(-light_x_i) : 14'd0;
  assign ay     = light_y_i[13] ? 14'(-light_y_i) : 14'd0;
  assign away   = (ax > ay) ? ax : ay;
  assign capped = (away > {2'b00, border}) ? border : away[11:0];
  assign n_fade = border - capped;
  assign up     = (imax_q >= imin_q);
  assign diff   = up ? (imax_q - imin_q) : (imin_q - imax_q);
  assign fade_prod = 20'(n_fade) * 20'(diff);
  assign cx     = sw_q[12:1];
  assign cy     = sh_q[12:1];

  logic signed [14:0] dx_q, dy_q;
  logic [11:0]        cx_q, cy_q, rem_q, border_q;
  logic [7:0]         dvd_q, quo_q, inten_q;

  // restoring divide, quotient < 256 so the top 12 bits start below the divisor
  logic [12:0] trial;
  logic        fits;
  assign trial = {rem_q, dvd_q[7]};
  assign fits  = (trial >= {1'b0, border_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q     <= $signed({3'b000, cx}) - 15'(light_x_i);
      dy_q     <= $signed({3'b000, cy}) - 15'(light_y_i);
      cx_q     <= cx;
      cy_q     <= cy;
      border_q <= border;
      rem_q    <= fade_prod[19:8];
      dvd_q    <= fade_prod[7:0];
      quo_q    <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? 12'(trial - {1'b0, border_q}) : trial[11:0];
      dvd_q <= {dvd_q[6:0], 1'b0};
      quo_q <= {quo_q[6:0], fits};
    end
    if (cmd_i.fin) begin
      inten_q <= up ? (imin_q + quo_q) : (imin_q - quo_q);
    end
  end

  // ---- per-spot quad
  spot_t              spot;
  logic signed [24:0] px_prod, py_prod, px_rnd, py_rnd;
  logic signed [17:0] px, py, half_s;
  logic [24:0]        half_prod;
  logic [15:0]        al_x;
  logic [8:0]         al_r;
  logic [8:0]         al_q;

  assign spot    = spot_entry(cmd_i.tab_idx);
  assign px_prod = dx_q * spot.line_pos;
  assign py_prod = dy_q * spot.line_pos;
  // divide by 256 rounding toward zero
  assign px_rnd  = px_prod + (px_prod[24] ? 25'sd255 : 25'sd0);
  assign py_rnd  = py_prod + (py_prod[24] ? 25'sd255 : 25'sd0);
  assign px      = $signed({6'b0, cx_q}) - 18'(px_rnd[24:8]);
  assign py      = $signed({6'b0, cy_q}) - 18'(py_rnd[24:8]);
  assign half_prod = 25'(sw_q) * 25'(spot.size);
  assign half_s  = $signed({6'b0, half_prod[24:13]});

  // (a*i + 127) / 255: x>>8 is at most one short
  assign al_x = 16'(spot.a) * 16'(inten_q) + 16'd127;
  assign al_r = 9'(al_x[7:0]) + 9'(al_x[15:8]);
  assign al_q = 9'(al_x[15:8]) + ((al_r >= 9'd255) ? 9'd1 : 9'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      spot_index_o     <= cmd_i.spot_index;
      texture_select_o <= spot.tex;
      quad_left_o      <= 16'(px - half_s);
      quad_top_o       <= 16'(py - half_s);
      quad_right_o     <= 16'(px + half_s);
      quad_bottom_o    <= 16'(py + half_s);
      red_o            <= spot.r;
      green_o          <= spot.g;
      blue_o           <= spot.b;
      alpha_o          <= al_q[8] ? 8'd255 : al_q[7:0];
      last_o           <= cmd_i.last;
    end
  end

endmodule

/* hdl/lens_flare_quad_generator_unit.sv */
// Lens flare quad generator.
// Input: pulse start with light_x_i, light_y_i and light_behind_i; the item is
// taken on the edge where start is high and busy is low. A behind-camera light
// is taken and dropped at once: no beats, busy stays low.
// Otherwise busy rises and the unit runs the divide steps (one quotient bit per
// cycle for the fade intensity), forms the intensity, then emits NUM_SPOTS beats.
// Each result beat sits on the output ports for one cycle, flagged by
// result_valid_o; beats of a run are back to back, last_o marks the final one.
// The first beat is registered from the first emit state; the next start is
// taken only once the last emit state has returned the unit to idle.
// The receiver has no back-pressure and must take every beat as shown.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i write one register per edge; the
// user must write only while busy is low (not enforced); unknown indexes ignored.
// Reset (rst_ni low, asynchronous) returns the controller to idle, drops
// result_valid_o and restores the register defaults (1024, 768, 0, 255, 300).
module lens_flare_quad_generator_unit #(
  parameter int unsigned NUM_SPOTS = lfqg_pkg::NUM_SPOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lfqg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lfqg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [13:0]              light_x_i,
  input  logic signed [13:0]              light_y_i,
  input  logic                            light_behind_i,
  output logic                            result_valid_o,
  output logic [3:0]                      spot_index_o,
  output logic [1:0]                      texture_select_o,
  output logic signed [15:0]              quad_left_o,
  output logic signed [15:0]              quad_top_o,
  output logic signed [15:0]              quad_right_o,
  output logic signed [15:0]              quad_bottom_o,
  output logic [7:0]                      red_o,
  output logic [7:0]                      green_o,
  output logic [7:0]                      blue_o,
  output logic [7:0]                      alpha_o,
  output logic                            last_o
);
  import lfqg_pkg::*;

  cmd_t cmd;

  // sequencing: divide steps, intensity, then one spot per cycle
  lfqg_ctrl #(
    .NUM_SPOTS(NUM_SPOTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .light_behind_i (light_behind_i),
    .busy           (busy),
    .cmd_o          (cmd)
  );

  // config regs, fade divider, quad maths and the output register
  lfqg_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .light_x_i        (light_x_i),
    .light_y_i        (light_y_i),
    .cmd_i            (cmd),
    .result_valid_o   (result_valid_o),
    .spot_index_o     (spot_index_o),
    .texture_select_o (texture_select_o),
    .quad_left_o      (quad_left_o),
    .quad_top_o       (quad_top_o),
    .quad_right_o     (quad_right_o),
    .quad_bottom_o    (quad_bottom_o),
    .red_o            (red_o),
    .green_o          (green_o),
    .blue_o           (blue_o),
    .alpha_o          (alpha_o),
    .last_o           (last_o)
  );

endmodule

/* hdl/lfqg_checker.sv */
module lfqg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       light_behind_i,
  input logic       result_valid_o,
  input logic [3:0] spot_index_o,
  input logic       last_o
);

  // beats of a run come back to back with rising spot index
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=>
      result_valid_o && (spot_index_o == 4'($past(spot_index_o) + 4'd1)))
    else $error("run broken or spot index out of order");

  // a run opens at spot zero
  a_run_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !$past(result_valid_o) |-> spot_index_o == 4'd0)
    else $error("run does not start at spot zero");

  // a dropped light gives no beat
  a_behind_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && light_behind_i |=> !result_valid_o)
    else $error("beat after a behind-camera item");

  // the final beat coincides with the unit going free
  a_last_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy)
    else $error("busy still high on final beat");

endmodule

bind lens_flare_quad_generator_unit lfqg_checker u_lfqg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .light_behind_i (light_behind_i),
  .result_valid_o (result_valid_o),
  .spot_index_o   (spot_index_o),
  .last_o         (last_o)
);
